// ----- hw/rtl/ahtm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ahtm_pkg
// Types and constants shared by the altitude hold throttle manager.
// ----------------------------------------------------------------------------
package ahtm_pkg;

    localparam int DRIFT_DIV  = 2000;
    localparam int THR_MARGIN = 100;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_CHANGE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_THR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_THR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_MODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_DIR   = 3'd5;

    localparam logic        RST_FAST_CHANGE = 1'b1;
    localparam logic [7:0]  RST_DEADBAND    = 8'd40;
    localparam logic [10:0] RST_MIN_THR     = 11'd1150;
    localparam logic [10:0] RST_MAX_THR     = 11'd1850;
    localparam logic        RST_PLANE_MODE  = 1'b0;
    localparam logic [1:0]  RST_PITCH_DIR   = 2'b01;

    // pitch direction codes, two bit signed
    localparam logic [1:0] DIR_ZERO    = 2'b00;
    localparam logic [1:0] DIR_POS     = 2'b01;
    localparam logic [1:0] DIR_NEG_TWO = 2'b10;
    localparam logic [1:0] DIR_NEG     = 2'b11;

    typedef struct packed {
        logic              fast_change;
        logic [7:0]        deadband;
        logic [10:0]       min_thr;
        logic [10:0]       max_thr;
        logic              plane_mode;
        logic signed [1:0] pitch_dir;
    } t_cfg;

    typedef struct packed {
        logic               hold_on;
        logic [10:0]        hold_thr;
        logic signed [31:0] alt_target;
        logic               stick_moved;
        logic signed [11:0] drift;
    } t_state;

    typedef struct packed {
        logic               hold_switch;
        logic [10:0]        throttle;
        logic signed [15:0] pitch;
        logic signed [31:0] est_alt;
        logic signed [15:0] pid;
    } t_item_in;

    typedef struct packed {
        logic [10:0]        throttle;
        logic signed [15:0] pitch;
        logic signed [31:0] target;
        logic               clr_int;
        logic               clr_pid;
        logic               hold_active;
    } t_item_out;

endpackage
`default_nettype wire

// ----- hw/rtl/altitude_hold_throttle_manager.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// altitude_hold_throttle_manager
// Altitude hold activation and throttle/pitch processing per control cycle.
// ----------------------------------------------------------------------------
// path: the input transfer loads the input register, then one combinational
//   pass through the core feeds the result register
// throughput: one item per cycle unless the output stalls; hold state is
//   read and written in that pass
// reset: hold state clears, registers take their default values, both
//   pipeline stages empty
module altitude_hold_throttle_manager (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output      logic                              o_stall,
    input  wire logic                              i_hold_switch,
    input  wire logic [10:0]                       i_throttle_in,
    input  wire logic signed [15:0]                i_pitch_in,
    input  wire logic signed [31:0]                i_est_altitude,
    input  wire logic signed [15:0]                i_pid_term,
    output      logic                              o_valid,
    input  wire logic                              i_stall,
    output      logic [10:0]                       o_throttle_out,
    output      logic signed [15:0]                o_pitch_out,
    output      logic signed [31:0]                o_target_altitude,
    output      logic                              o_clear_integral,
    output      logic                              o_clear_pid,
    output      logic                              o_hold_active,
    input  wire logic                              i_cfg_valid,
    output      logic                              o_cfg_ready,
    input  wire logic [ahtm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [10:0]                       i_cfg_data
);
    import ahtm_pkg::*;

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_item_in  r_in;
    t_state    r_state;
    t_state    n_state;
    logic      r_out_valid;
    t_item_out r_out;
    t_item_out n_out;
    logic      out_open;
    logic      advance;

    assign out_open    = !r_out_valid || !i_stall;
    assign advance     = r_in_valid && out_open;
    assign o_stall     = r_in_valid && !out_open;
    assign o_cfg_ready = 1'b1;

    ahtm_core u_core (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state),
        .o_item  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_change <= RST_FAST_CHANGE;
            r_cfg.deadband    <= RST_DEADBAND;
            r_cfg.min_thr     <= RST_MIN_THR;
            r_cfg.max_thr     <= RST_MAX_THR;
            r_cfg.plane_mode  <= RST_PLANE_MODE;
            r_cfg.pitch_dir   <= RST_PITCH_DIR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FAST_CHANGE: r_cfg.fast_change <= i_cfg_data[0];
                CFG_DEADBAND:    r_cfg.deadband    <= i_cfg_data[7:0];
                CFG_MIN_THR:     r_cfg.min_thr     <= i_cfg_data;
                CFG_MAX_THR:     r_cfg.max_thr     <= i_cfg_data;
                CFG_PLANE_MODE:  r_cfg.plane_mode  <= i_cfg_data[0];
                CFG_PITCH_DIR:   r_cfg.pitch_dir   <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_open) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in.hold_switch <= i_hold_switch;
            r_in.throttle    <= i_throttle_in;
            r_in.pitch       <= i_pitch_in;
            r_in.est_alt     <= i_est_altitude;
            r_in.pid         <= i_pid_term;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_throttle_out    = r_out.throttle;
    assign o_pitch_out       = r_out.pitch;
    assign o_target_altitude = r_out.target;
    assign o_clear_integral  = r_out.clr_int;
    assign o_clear_pid       = r_out.clr_pid;
    assign o_hold_active     = r_out.hold_active;

    // activation clears both the pid term and the integrator
    a_clr_pid_implies_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.clr_pid |-> r_out.clr_int && r_out.hold_active)
        else $error("clear_pid without clear_integral or hold");

    // drift remainder stays below the divisor in magnitude
    a_drift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.drift < 12'sd2000 && r_state.drift > -12'sd2000)
        else $error("drift accumulator out of range");

    // hold state only moves when an item passes into the result register
    a_state_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("hold state changed without an item");

    // a stalled input stage must hold an item
    a_stall_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid)
        else $error("input stall with empty pipeline");

endmodule
`default_nettype wire

// ----- hw/rtl/ahtm_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ahtm_core
// One control cycle of hold activation, throttle deadband handling, target
// drift and fixed wing pitch correction, from current state to next state.
// ----------------------------------------------------------------------------
module ahtm_core (
    input  ahtm_pkg::t_cfg      i_cfg,
    input  ahtm_pkg::t_state    i_state,
    input  ahtm_pkg::t_item_in  i_item,
    output ahtm_pkg::t_state    o_state,
    output ahtm_pkg::t_item_out o_item
);
    import ahtm_pkg::*;

    localparam logic signed [12:0] DIV1 = 13'(DRIFT_DIV);
    localparam logic signed [12:0] DIV2 = 13'(2 * DRIFT_DIV);

    logic               act;
    logic [10:0]        hold_thr_e;
    logic signed [31:0] target_e;
    logic signed [15:0] pid_e;
    logic signed [11:0] diff;
    logic [10:0]        mag;
    logic               outside;
    logic [11:0]        lo_u;
    logic signed [17:0] sum, lo_s, hi_s, clp;
    logic [10:0]        thr_clamp;
    logic signed [17:0] pid_ext, prod, pitch_sum;
    logic signed [15:0] pitch_sat;
    logic signed [12:0] acc, rem;
    logic signed [2:0]  quo;

    always_comb begin
        // activation latches target and throttle, pid counts as zero
        act        = i_item.hold_switch && !i_state.hold_on;
        hold_thr_e = act ? i_item.throttle : i_state.hold_thr;
        target_e   = act ? i_item.est_alt : i_state.alt_target;
        pid_e      = act ? 16'sd0 : i_item.pid;

        diff    = $signed({1'b0, i_item.throttle}) - $signed({1'b0, hold_thr_e});
        mag     = diff[11] ? 11'(-diff) : diff[10:0];
        outside = mag > {3'b000, i_cfg.deadband};

        // clamp, lower bound checked first, so a sum at or above both bounds takes the upper
        lo_u = {1'b0, i_cfg.min_thr} + 12'(THR_MARGIN);
        lo_s = $signed({6'b0, lo_u});
        hi_s = $signed({7'b0, i_cfg.max_thr});
        sum  = $signed({7'b0, hold_thr_e}) + $signed({{2{pid_e[15]}}, pid_e});
        if (sum < lo_s) begin
            clp = lo_s;
        end else if (sum > hi_s) begin
            clp = hi_s;
        end else begin
            clp = sum;
        end
        thr_clamp = (clp > 18'sd2047) ? 11'h7FF : clp[10:0];

        // fixed wing pitch correction
        pid_ext = $signed({{2{pid_e[15]}}, pid_e});
        unique case (i_cfg.pitch_dir)
            DIR_ZERO:    prod = 18'sd0;
            DIR_POS:     prod = pid_ext;
            DIR_NEG:     prod = -pid_ext;
            DIR_NEG_TWO: prod = -(pid_ext <<< 1);
            default:     prod = 18'sd0;
        endcase
        pitch_sum = $signed({{2{i_item.pitch[15]}}, i_item.pitch}) + prod;
        if (pitch_sum > 18'sd32767) begin
            pitch_sat = 16'sh7FFF;
        end else if (pitch_sum < -18'sd32768) begin
            pitch_sat = -16'sh8000;
        end else begin
            pitch_sat = pitch_sum[15:0];
        end

        // slow drift: truncating quotient and remainder by the drift divisor
        acc = $signed({i_state.drift[11], i_state.drift}) + $signed({diff[11], diff});
        if (acc >= DIV2) begin
            quo = 3'sd2;
            rem = acc - DIV2;
        end else if (acc >= DIV1) begin
            quo = 3'sd1;
            rem = acc - DIV1;
        end else if (acc <= -DIV2) begin
            quo = -3'sd2;
            rem = acc + DIV2;
        end else if (acc <= -DIV1) begin
            quo = -3'sd1;
            rem = acc + DIV1;
        end else begin
            quo = 3'sd0;
            rem = acc;
        end

        o_state             = i_state;
        o_state.hold_on     = i_item.hold_switch;
        o_state.hold_thr    = hold_thr_e;
        o_state.alt_target  = target_e;

        o_item.throttle    = i_item.throttle;
        o_item.pitch       = i_item.pitch;
        o_item.clr_int     = act;
        o_item.clr_pid     = act;
        o_item.hold_active = i_item.hold_switch;

        if (i_item.hold_switch) begin
            if (i_cfg.plane_mode) begin
                o_item.pitch = pitch_sat;
            end else if (i_cfg.fast_change) begin
                if (outside) begin
                    o_item.clr_int      = 1'b1;
                    o_state.stick_moved = 1'b1;
                    if (i_item.throttle > hold_thr_e) begin
                        o_item.throttle = i_item.throttle - 11'(i_cfg.deadband);
                    end else begin
                        o_item.throttle = i_item.throttle + 11'(i_cfg.deadband);
                    end
                end else begin
                    if (i_state.stick_moved) begin
                        o_state.alt_target  = i_item.est_alt;
                        o_state.stick_moved = 1'b0;
                    end
                    o_item.throttle = thr_clamp;
                end
            end else begin
                if (outside) begin
                    o_state.drift       = rem[11:0];
                    o_state.alt_target  = target_e + $signed({{29{quo[2]}}, quo});
                    o_state.stick_moved = 1'b1;
                end else if (i_state.stick_moved) begin
                    o_state.alt_target  = i_item.est_alt;
                    o_state.drift       = 12'sd0;
                    o_state.stick_moved = 1'b0;
                end
                o_item.throttle = thr_clamp;
            end
        end

        o_item.target = o_state.alt_target;
    end

endmodule
`default_nettype wire

// ----- tb/altitude_hold_throttle_manager_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altitude_hold_throttle_manager_tb
// Drives control cycles through the hold manager under random source gaps and
// sink stalls, predicts every command with a cycle model kept here and
// compares each output transfer field by field. Register settings change
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module altitude_hold_throttle_manager_tb;
    import ahtm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 100;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_PULSE} t_stall_mode;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_stall;
    logic               i_hold_switch  = 1'b0;
    logic [10:0]        i_throttle_in  = '0;
    logic signed [15:0] i_pitch_in     = '0;
    logic signed [31:0] i_est_altitude = '0;
    logic signed [15:0] i_pid_term     = '0;
    logic               o_valid;
    logic               i_stall        = 1'b0;
    logic [10:0]        o_throttle_out;
    logic signed [15:0] o_pitch_out;
    logic signed [31:0] o_target_altitude;
    logic               o_clear_integral;
    logic               o_clear_pid;
    logic               o_hold_active;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [10:0]        i_cfg_data     = '0;

    altitude_hold_throttle_manager dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_hold_switch     (i_hold_switch),
        .i_throttle_in     (i_throttle_in),
        .i_pitch_in        (i_pitch_in),
        .i_est_altitude    (i_est_altitude),
        .i_pid_term        (i_pid_term),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_throttle_out    (o_throttle_out),
        .o_pitch_out       (o_pitch_out),
        .o_target_altitude (o_target_altitude),
        .o_clear_integral  (o_clear_integral),
        .o_clear_pid       (o_clear_pid),
        .o_hold_active     (o_hold_active),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // register copy
    bit          fast_mode;
    int          dband;
    int          min_thr;
    int          max_thr;
    bit          plane_mode;
    int          pitch_mul;
    // hold state copy
    bit          hold_en;
    int          hold_thr;
    logic [31:0] tgt;
    bit          moved;
    int          drift;

    t_item_in    control_cycles_q[$];
    t_item_out   expected_cmds_q[$];
    t_item_in    taken_cycle;
    t_item_out   seen_cmd;

    bit          cycle_taken;
    int          gap_left;
    int          burst_left;
    t_stall_mode stall_mode;
    int          stall_left;

    int          mismatch_cnt;
    int          cycles_sent;
    int          results_checked;
    int          reg_writes;
    int          activations;
    int          stick_outside;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int dir_mult(logic [1:0] code);
        case (code)
            DIR_POS:     return 1;
            DIR_NEG:     return -1;
            DIR_NEG_TWO: return -2;
            default:     return 0;
        endcase
    endfunction

    function automatic void reset_model();
        fast_mode  = RST_FAST_CHANGE;
        dband      = int'(RST_DEADBAND);
        min_thr    = int'(RST_MIN_THR);
        max_thr    = int'(RST_MAX_THR);
        plane_mode = RST_PLANE_MODE;
        pitch_mul  = dir_mult(RST_PITCH_DIR);
        hold_en    = 1'b0;
        hold_thr   = 0;
        tgt        = '0;
        moved      = 1'b0;
        drift      = 0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [10:0] val);
        case (idx)
            CFG_FAST_CHANGE: fast_mode  = val[0];
            CFG_DEADBAND:    dband      = int'(val[7:0]);
            CFG_MIN_THR:     min_thr    = int'(val);
            CFG_MAX_THR:     max_thr    = int'(val);
            CFG_PLANE_MODE:  plane_mode = val[0];
            CFG_PITCH_DIR:   pitch_mul  = dir_mult(val[1:0]);
            default: ;
        endcase
    endfunction

    // lower bound checked first, then the upper bound; then fit into 11 bits
    function automatic int clamp_hold_throttle(int pid);
        int lo;
        int v;
        lo = min_thr + THR_MARGIN;
        v  = hold_thr + pid;
        if (v < lo) begin
            v = lo;
        end else if (v > max_thr) begin
            v = max_thr;
        end
        if (v > 2047) v = 2047;
        if (v < 0) v = 0;
        return v;
    endfunction

    function automatic t_item_out predict_hold_step(t_item_in it);
        t_item_out r;
        int        thr;
        int        pitch;
        int        pid;
        int        diff;
        int        mag;
        int        step;
        bit        outside;
        r     = '0;
        thr   = int'(it.throttle);
        pitch = int'($signed(it.pitch));
        pid   = int'($signed(it.pid));
        if (it.hold_switch) begin
            if (!hold_en) begin
                hold_en   = 1'b1;
                tgt       = it.est_alt;
                hold_thr  = thr;
                r.clr_int = 1'b1;
                r.clr_pid = 1'b1;
                pid       = 0;
                activations++;
            end
        end else begin
            hold_en = 1'b0;
        end
        if (hold_en && plane_mode) begin
            pitch = pitch + pid * pitch_mul;
            if (pitch > 32767) pitch = 32767;
            if (pitch < -32768) pitch = -32768;
        end else if (hold_en) begin
            diff    = thr - hold_thr;
            mag     = (diff < 0) ? -diff : diff;
            outside = mag > dband;
            if (outside) stick_outside++;
            if (fast_mode) begin
                if (outside) begin
                    r.clr_int = 1'b1;
                    moved     = 1'b1;
                    if (thr > hold_thr) thr -= dband;
                    else thr += dband;
                end else begin
                    if (moved) begin
                        tgt   = it.est_alt;
                        moved = 1'b0;
                    end
                    thr = clamp_hold_throttle(pid);
                end
            end else begin
                if (outside) begin
                    // keep the division signed, then add modulo 2^32
                    drift += diff;
                    step  = drift / DRIFT_DIV;
                    tgt   = tgt + step;
                    drift = drift % DRIFT_DIV;
                    moved = 1'b1;
                end else if (moved) begin
                    tgt   = it.est_alt;
                    drift = 0;
                    moved = 1'b0;
                end
                thr = clamp_hold_throttle(pid);
            end
        end
        r.throttle    = thr[10:0];
        r.pitch       = pitch[15:0];
        r.target      = tgt;
        r.hold_active = hold_en;
        return r;
    endfunction

    task automatic check_result(t_item_out want, t_item_out seen);
        if (seen.throttle !== want.throttle) begin
            $error("throttle_out expected %0d got %0d", want.throttle, seen.throttle);
            mismatch_cnt++;
        end
        if (seen.pitch !== want.pitch) begin
            $error("pitch_out expected %0d got %0d", $signed(want.pitch), $signed(seen.pitch));
            mismatch_cnt++;
        end
        if (seen.target !== want.target) begin
            $error("target_altitude expected %0d got %0d",
                   $signed(want.target), $signed(seen.target));
            mismatch_cnt++;
        end
        if (seen.clr_int !== want.clr_int) begin
            $error("clear_integral expected %0d got %0d", want.clr_int, seen.clr_int);
            mismatch_cnt++;
        end
        if (seen.clr_pid !== want.clr_pid) begin
            $error("clear_pid expected %0d got %0d", want.clr_pid, seen.clr_pid);
            mismatch_cnt++;
        end
        if (seen.hold_active !== want.hold_active) begin
            $error("hold_active expected %0d got %0d", want.hold_active, seen.hold_active);
            mismatch_cnt++;
        end
    endtask

    // output check and input prediction, both on the transfer edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                seen_cmd.throttle    = o_throttle_out;
                seen_cmd.pitch       = o_pitch_out;
                seen_cmd.target      = o_target_altitude;
                seen_cmd.clr_int     = o_clear_integral;
                seen_cmd.clr_pid     = o_clear_pid;
                seen_cmd.hold_active = o_hold_active;
                if (expected_cmds_q.size() == 0) begin
                    $error("output transfer with no command expected");
                    mismatch_cnt++;
                end else begin
                    check_result(expected_cmds_q.pop_front(), seen_cmd);
                end
                results_checked++;
            end
            if (i_valid && !o_stall) begin
                taken_cycle.hold_switch = i_hold_switch;
                taken_cycle.throttle    = i_throttle_in;
                taken_cycle.pitch       = i_pitch_in;
                taken_cycle.est_alt     = i_est_altitude;
                taken_cycle.pid         = i_pid_term;
                expected_cmds_q.push_back(predict_hold_step(taken_cycle));
                control_cycles_q.delete(0);
                cycles_sent++;
                cycle_taken = 1'b1;
            end
        end
    end

    // source in bursts, sink stalls on its own pattern
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || cycle_taken) begin
            cycle_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (control_cycles_q.size() > 0) begin
                i_valid        <= 1'b1;
                i_hold_switch  <= control_cycles_q[0].hold_switch;
                i_throttle_in  <= control_cycles_q[0].throttle;
                i_pitch_in     <= control_cycles_q[0].pitch;
                i_est_altitude <= control_cycles_q[0].est_alt;
                i_pid_term     <= control_cycles_q[0].pid;
                if (burst_left > 1) begin
                    burst_left--;
                end else if ($urandom_range(0, 3) == 0) begin
                    burst_left = $urandom_range(30, 90);
                    gap_left   = 0;
                end else begin
                    burst_left = $urandom_range(1, 8);
                    gap_left   = $urandom_range(0, 6);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 120);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HALF:  i_stall <= 1'($urandom_range(0, 1));
            default:     i_stall <= ((stall_left % 7) < 4);
        endcase
    end

    task automatic push_item(bit sw, logic [10:0] thr, logic [15:0] pitch,
                             logic [31:0] est, logic [15:0] pid);
        t_item_in c;
        c.hold_switch = sw;
        c.throttle    = thr;
        c.pitch       = pitch;
        c.est_alt     = est;
        c.pid         = pid;
        control_cycles_q.push_back(c);
    endtask

    // block idle: no cycle pending, every command seen, pipeline drained
    task automatic wait_idle();
        while (control_cycles_q.size() != 0 || expected_cmds_q.size() != 0)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [10:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, val);
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // unused upper data bits carry noise
    task automatic set_config(bit fast, int db, int mn, int mx, bit fw, logic [1:0] dir);
        logic [10:0] junk;
        junk = 11'($urandom);
        write_reg(CFG_FAST_CHANGE, {junk[10:1], fast});
        junk = 11'($urandom);
        write_reg(CFG_DEADBAND, {junk[10:8], db[7:0]});
        write_reg(CFG_MIN_THR, mn[10:0]);
        write_reg(CFG_MAX_THR, mx[10:0]);
        junk = 11'($urandom);
        write_reg(CFG_PLANE_MODE, {junk[10:1], fw});
        junk = 11'($urandom);
        write_reg(CFG_PITCH_DIR, {junk[10:2], dir});
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 11'($urandom));
    endtask

    function automatic int pick_thr_limit();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 2047;
            2:       return $urandom_range(1000, 1900);
            default: return $urandom_range(0, 2047);
        endcase
    endfunction

    // short idle stretches, then an engaged run around one stick position
    task automatic gen_flights(int n);
        int          made;
        int          len;
        int          center;
        int          off;
        int          thr;
        int          pid;
        logic [31:0] base;
        logic [31:0] est;
        bit          sw;
        made = 0;
        while (made < n) begin
            len = $urandom_range(0, 3);
            for (int k = 0; k < len; k++)
                push_item(1'b0, 11'($urandom_range(0, 2047)), 16'($urandom), $urandom,
                          16'($urandom));
            made += len;
            center = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2047)
                                                  : $urandom_range(1000, 1800);
            if ($urandom_range(0, 4) == 0)
                base = $urandom_range(0, 1) ? 32'h7FFF_FF80 : 32'h8000_0040;
            else
                base = $urandom_range(0, 100000);
            len = $urandom_range(3, 40);
            for (int k = 0; k < len; k++) begin
                sw = (k == 0) || ($urandom_range(0, 24) != 0);
                case ($urandom_range(0, 5))
                    0, 1:    off = $urandom_range(0, 2 * dband) - dband;
                    2:       off = ($urandom_range(0, 1) ? 1 : -1) * (dband + $urandom_range(0, 1));
                    3:       off = ($urandom_range(0, 1) ? 1 : -1) * (dband + $urandom_range(1, 600));
                    4:       off = $urandom_range(0, 2047) - center;
                    default: off = 0;
                endcase
                thr = (k == 0) ? center : center + off;
                if (thr < 0) thr = 0;
                if (thr > 2047) thr = 2047;
                if ($urandom_range(0, 9) == 0) est = $urandom;
                else est = base + $urandom_range(0, 400) - 200;
                if ($urandom_range(0, 3) == 0) pid = $urandom;
                else pid = $urandom_range(0, 1000) - 500;
                push_item(sw, thr[10:0], 16'($urandom), est, pid[15:0]);
            end
            made += len;
        end
    endtask

    initial begin
        reset_model();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fast change at reset settings: pass-through, edges of the deadband, retarget
        push_item(1'b0, 11'd0, 16'h8000, 32'h7FFF_FFFF, 16'h7FFF);
        push_item(1'b0, 11'd2047, 16'h7FFF, 32'h8000_0000, 16'h8000);
        push_item(1'b1, 11'd1500, 16'd0, 32'd1000, 16'd300);
        push_item(1'b1, 11'd1540, 16'd5, 32'd1200, 16'd400);
        push_item(1'b1, 11'd1541, 16'd5, 32'd1300, 16'd0);
        push_item(1'b1, 11'd1400, 16'd0, 32'd1400, 16'd0);
        push_item(1'b1, 11'd1500, 16'd0, 32'd5000, -16'sd1000);
        push_item(1'b0, 11'd1500, 16'd0, 32'd0, 16'd0);
        push_item(1'b1, 11'd2047, 16'd0, -32'sd7, 16'd0);
        push_item(1'b1, 11'd0, 16'd0, 32'd0, 16'd0);
        push_item(1'b0, 11'd0, 16'd0, 32'd0, 16'd0);
        wait_idle();

        // slow drift: remainder carry, target wrap in both directions
        set_config(1'b0, 40, 1150, 1850, 1'b0, DIR_POS);
        push_item(1'b1, 11'd1000, 16'd0, 32'h7FFF_FFFF, 16'd0);
        push_item(1'b1, 11'd2047, 16'd0, 32'd0, 16'd0);
        push_item(1'b1, 11'd2047, 16'd0, 32'd0, 16'd0);
        push_item(1'b1, 11'd1030, 16'd0, 32'd55, 16'd2000);
        push_item(1'b0, 11'd1000, 16'd0, 32'd0, 16'd0);
        push_item(1'b1, 11'd1000, 16'd0, 32'h8000_0000, 16'd0);
        push_item(1'b1, 11'd0, 16'd0, 32'd0, 16'd0);
        push_item(1'b1, 11'd0, 16'd0, 32'd0, 16'd0);
        push_item(1'b1, 11'd0, 16'd0, 32'd0, 16'h8000);
        push_item(1'b0, 11'd0, 16'd0, 32'd0, 16'd0);
        wait_idle();

        // fixed wing pitch saturation
        set_config(1'b1, 40, 1150, 1850, 1'b1, DIR_NEG_TWO);
        push_item(1'b1, 11'd1234, 16'h7FFF, 32'd10, 16'h7FFF);
        push_item(1'b1, 11'd1234, 16'h8000, 32'd10, 16'h7FFF);
        push_item(1'b1, 11'd2047, 16'h7FFF, 32'd10, 16'h8000);
        push_item(1'b1, 11'd0, 16'd100, 32'd10, 16'd7);
        push_item(1'b0, 11'd5, 16'd5, 32'd5, 16'd5);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       set_config(1'b1, 0, 0, 2047, 1'b0, DIR_ZERO);
                1:       set_config(1'b0, 255, 2047, 0, 1'b0, DIR_NEG);
                2:       set_config(1'b1, 255, 0, 0, 1'b1, DIR_ZERO);
                3:       set_config(1'b0, 0, 2047, 2047, 1'b1, DIR_NEG);
                default: set_config(1'($urandom_range(0, 1)),
                                    $urandom_range(0, 1) ? $urandom_range(0, 255)
                                                         : $urandom_range(20, 60),
                                    pick_thr_limit(), pick_thr_limit(),
                                    $urandom_range(0, 3) == 0, 2'($urandom));
            endcase
            gen_flights(PHASE_ITEMS);
            wait_idle();
        end
        repeat (10) @(posedge i_clk);

        $display("checked %0d commands from %0d control cycles, %0d register writes",
                 results_checked, cycles_sent, reg_writes);
        $display("hold engaged %0d times, stick outside deadband on %0d cycles",
                 activations, stick_outside);
        if (mismatch_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #(64'd20_000_000);
        $display("timeout with %0d cycles pending, %0d commands expected",
                 control_cycles_q.size(), expected_cmds_q.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/ahtm_pkg.sv
hw/rtl/ahtm_core.sv
hw/rtl/altitude_hold_throttle_manager.sv
tb/altitude_hold_throttle_manager_tb.sv
